FILE: src/trfp_pkg.sv
// trfp_pkg: shared constants, types and helpers for the two-ray fixation point block
// no dependencies; compiled first

package trfp_pkg;

  // restoring divider: quotient bits resolved per pipeline stage
  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned QUO_W     = 32;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // one squared in Q.60
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

  // side data that rides alongside the divider
  typedef struct packed {
    logic [2:0][31:0] dl;
    logic [2:0][31:0] dr;
    logic [2:0][32:0] ps;
    logic             par;
  } trfp_side_t;

  // saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -66'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/trfp_if.sv
// trfp_in_if / trfp_out_if: valid-ready channels for ray pairs and fixation words
// no dependencies

interface trfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_origin_x;
  logic signed [31:0] left_origin_y;
  logic signed [31:0] left_origin_z;
  logic signed [31:0] left_dir_x;
  logic signed [31:0] left_dir_y;
  logic signed [31:0] left_dir_z;
  logic signed [31:0] right_origin_x;
  logic signed [31:0] right_origin_y;
  logic signed [31:0] right_origin_z;
  logic signed [31:0] right_dir_x;
  logic signed [31:0] right_dir_y;
  logic signed [31:0] right_dir_z;

  modport source (output valid, left_origin_x, left_origin_y, left_origin_z,
                  left_dir_x, left_dir_y, left_dir_z, right_origin_x, right_origin_y,
                  right_origin_z, right_dir_x, right_dir_y, right_dir_z,
                  input ready);
  modport sink   (input valid, left_origin_x, left_origin_y, left_origin_z,
                  left_dir_x, left_dir_y, left_dir_z, right_origin_x, right_origin_y,
                  right_origin_z, right_dir_x, right_dir_y, right_dir_z,
                  output ready);
endinterface

interface trfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fix_x;
  logic signed [31:0] fix_y;
  logic signed [31:0] fix_z;
  logic               parallel_flag;

  modport source (output valid, fix_x, fix_y, fix_z, parallel_flag, input ready);
  modport sink   (input valid, fix_x, fix_y, fix_z, parallel_flag, output ready);
endinterface

FILE: src/two_ray_fixation_point.sv
// two_ray_fixation_point: midpoint of closest approach of two rays, fully pipelined
// depends on trfp_pkg, trfp_if (trfp_in_if, trfp_out_if) and trfp_div
//
//   channel  | dir | handshake      | payload
//   in_i     | in  | valid / ready  | left/right origin (Q16.16), left/right dir (Q1.30)
//   out_o    | out | valid / ready  | fix_x/y/z (Q16.16), parallel_flag
//
// one ray pair enters per cycle while out_o is not stalled; the line parameters are
// computed by the two restoring dividers
// reset clears only the valid bits; no clearing pass, block is ready right after reset
// a stall on out_o freezes every stage at once, so ready on in_i follows it in the same cycle

module two_ray_fixation_point import trfp_pkg::*; #(
  parameter int unsigned DivSteps = DIV_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trfp_in_if.sink     in_i,
  trfp_out_if.source  out_o
);

  localparam int unsigned DivLat = QUO_W / DivSteps + 1;

  logic adv;
  logic out_valid_q;

  // whole pipeline moves when the output word is free or being taken
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // stage a: register inputs, offset and origin sum
  logic               a_v_q;
  logic signed [31:0] a_dl_q [3];
  logic signed [31:0] a_dr_q [3];
  logic signed [32:0] a_w_q  [3];
  logic signed [32:0] a_ps_q [3];
  logic signed [31:0] pl [3];
  logic signed [31:0] pr [3];
  logic signed [31:0] dl [3];
  logic signed [31:0] dr [3];

  assign pl[0] = in_i.left_origin_x;
  assign pl[1] = in_i.left_origin_y;
  assign pl[2] = in_i.left_origin_z;
  assign pr[0] = in_i.right_origin_x;
  assign pr[1] = in_i.right_origin_y;
  assign pr[2] = in_i.right_origin_z;
  assign dl[0] = in_i.left_dir_x;
  assign dl[1] = in_i.left_dir_y;
  assign dl[2] = in_i.left_dir_z;
  assign dr[0] = in_i.right_dir_x;
  assign dr[1] = in_i.right_dir_y;
  assign dr[2] = in_i.right_dir_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_dl_q[i] <= dl[i];
        a_dr_q[i] <= dr[i];
        a_w_q[i]  <= 33'(pl[i]) - 33'(pr[i]);
        a_ps_q[i] <= 33'(pl[i]) + 33'(pr[i]);
      end
    end
  end

  // stage b: nine products for the dot products
  logic               b_v_q;
  logic signed [63:0] b_cc_q [3];
  logic signed [64:0] b_dw_q [3];
  logic signed [64:0] b_ew_q [3];
  logic signed [31:0] b_dl_q [3];
  logic signed [31:0] b_dr_q [3];
  logic signed [32:0] b_ps_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_cc_q[i] <= a_dl_q[i] * a_dr_q[i];
        b_dw_q[i] <= a_dl_q[i] * a_w_q[i];
        b_ew_q[i] <= a_dr_q[i] * a_w_q[i];
        b_dl_q[i] <= a_dl_q[i];
        b_dr_q[i] <= a_dr_q[i];
        b_ps_q[i] <= a_ps_q[i];
      end
    end
  end

  // stage c: scale, sum and saturate c, d, e
  logic               c_v_q;
  logic signed [31:0] c_c_q, c_d_q, c_e_q;
  logic signed [31:0] c_dl_q [3];
  logic signed [31:0] c_dr_q [3];
  logic signed [32:0] c_ps_q [3];
  logic signed [65:0] c_sum, d_sum, e_sum;

  always_comb begin
    c_sum = '0;
    d_sum = '0;
    e_sum = '0;
    for (int i = 0; i < 3; i++) begin
      c_sum = c_sum + 66'(b_cc_q[i] >>> 30);
      d_sum = d_sum + 66'(b_dw_q[i] >>> 30);
      e_sum = e_sum + 66'(b_ew_q[i] >>> 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_c_q  <= sat32(c_sum);
      c_d_q  <= sat32(d_sum);
      c_e_q  <= sat32(e_sum);
      c_dl_q <= b_dl_q;
      c_dr_q <= b_dr_q;
      c_ps_q <= b_ps_q;
    end
  end

  // stage d: c*c, c*e, c*d
  logic               d_v_q;
  logic signed [63:0] d_cc_q, d_ce_q, d_cd_q;
  logic signed [31:0] d_d_q, d_e_q;
  logic signed [31:0] d_dl_q [3];
  logic signed [31:0] d_dr_q [3];
  logic signed [32:0] d_ps_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_cc_q <= c_c_q * c_c_q;
      d_ce_q <= c_c_q * c_e_q;
      d_cd_q <= c_c_q * c_d_q;
      d_d_q  <= c_d_q;
      d_e_q  <= c_e_q;
      d_dl_q <= c_dl_q;
      d_dr_q <= c_dr_q;
      d_ps_q <= c_ps_q;
    end
  end

  // stage e: denominator and the two numerators
  logic               e_v_q;
  logic signed [33:0] e_den_q;
  logic signed [63:0] e_nl_q, e_nr_q;
  logic signed [31:0] e_dl_q [3];
  logic signed [31:0] e_dr_q [3];
  logic signed [32:0] e_ps_q [3];
  logic signed [63:0] den_full;

  assign den_full = d_cc_q - ONE_Q60;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_den_q <= 34'(den_full >>> 30);
      e_nl_q  <= (64'(d_d_q) <<< 30) - d_ce_q;
      e_nr_q  <= d_cd_q - (64'(d_e_q) <<< 30);
      e_dl_q  <= d_dl_q;
      e_dr_q  <= d_dr_q;
      e_ps_q  <= d_ps_q;
    end
  end

  // stage f: magnitudes and quotient signs for the dividers
  logic               f_v_q;
  logic [62:0]        f_nl_mag_q, f_nr_mag_q;
  logic [32:0]        f_den_mag_q;
  logic               f_nl_neg_q, f_nr_neg_q;
  trfp_side_t         f_side_q;
  logic signed [63:0] nl_abs, nr_abs;
  logic signed [33:0] den_abs;

  assign nl_abs  = e_nl_q[63]  ? -e_nl_q  : e_nl_q;
  assign nr_abs  = e_nr_q[63]  ? -e_nr_q  : e_nr_q;
  assign den_abs = e_den_q[33] ? -e_den_q : e_den_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_nl_mag_q  <= nl_abs[62:0];
      f_nr_mag_q  <= nr_abs[62:0];
      f_den_mag_q <= den_abs[32:0];
      f_nl_neg_q  <= e_nl_q[63] ^ e_den_q[33];
      f_nr_neg_q  <= e_nr_q[63] ^ e_den_q[33];
      for (int i = 0; i < 3; i++) begin
        f_side_q.dl[i] <= e_dl_q[i];
        f_side_q.dr[i] <= e_dr_q[i];
        f_side_q.ps[i] <= e_ps_q[i];
      end
      f_side_q.par <= (e_den_q == '0);
    end
  end

  // line parameter dividers
  logic              tl_v, tr_v;
  logic [QUO_W-1:0]  tl_quo, tr_quo;
  logic              tl_ovf, tr_ovf, tl_neg, tr_neg;

  trfp_div #(.StepsPerStage(DivSteps)) u_div_tl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_v_q),
    .num_i   (f_nl_mag_q),
    .den_i   (f_den_mag_q),
    .neg_i   (f_nl_neg_q),
    .valid_o (tl_v),
    .quo_o   (tl_quo),
    .ovf_o   (tl_ovf),
    .neg_o   (tl_neg)
  );

  trfp_div #(.StepsPerStage(DivSteps)) u_div_tr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_v_q),
    .num_i   (f_nr_mag_q),
    .den_i   (f_den_mag_q),
    .neg_i   (f_nr_neg_q),
    .valid_o (tr_v),
    .quo_o   (tr_quo),
    .ovf_o   (tr_ovf),
    .neg_o   (tr_neg)
  );

  // side data delay matching the divider latency
  trfp_side_t side_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= f_side_q;
      for (int k = 1; k < DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage g: sign and saturate the line parameters
  logic               g_v_q;
  logic signed [31:0] g_tl_q, g_tr_q;
  trfp_side_t         g_side_q;

  function automatic logic signed [31:0] quo_sat(input logic [QUO_W-1:0] q,
                                                 input logic ovf, input logic neg);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? S32_MIN : S32_MAX;
    end else if (neg) begin
      r = ({1'b0, q} > 33'h0_8000_0000) ? S32_MIN : -$signed(q);
    end else begin
      r = q[31] ? S32_MAX : $signed(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_tl_q   <= quo_sat(tl_quo, tl_ovf, tl_neg);
      g_tr_q   <= quo_sat(tr_quo, tr_ovf, tr_neg);
      g_side_q <= side_q[DivLat-1];
    end
  end

  // stage h: parameter times direction
  logic               h_v_q;
  logic signed [63:0] h_pl_q [3];
  logic signed [63:0] h_pr_q [3];
  logic signed [32:0] h_ps_q [3];
  logic               h_par_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h_pl_q[i] <= g_tl_q * $signed(g_side_q.dl[i]);
        h_pr_q[i] <= g_tr_q * $signed(g_side_q.dr[i]);
        h_ps_q[i] <= $signed(g_side_q.ps[i]);
      end
      h_par_q <= g_side_q.par;
    end
  end

  // output stage: midpoint, saturate, zero on parallel rays
  logic signed [31:0] fix_d [3];
  logic signed [31:0] fix_q [3];
  logic               par_q;

  always_comb begin
    logic signed [65:0] s;
    for (int i = 0; i < 3; i++) begin
      s = 66'(h_ps_q[i]) + 66'(h_pl_q[i] >>> 30) + 66'(h_pr_q[i] >>> 30);
      fix_d[i] = h_par_q ? '0 : sat32(s >>> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_q <= fix_d;
      par_q <= h_par_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      d_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
      f_v_q       <= 1'b0;
      g_v_q       <= 1'b0;
      h_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_v_q       <= in_i.valid;
      b_v_q       <= a_v_q;
      c_v_q       <= b_v_q;
      d_v_q       <= c_v_q;
      e_v_q       <= d_v_q;
      f_v_q       <= e_v_q;
      g_v_q       <= tl_v;
      h_v_q       <= g_v_q;
      out_valid_q <= h_v_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fix_x         = fix_q[0];
  assign out_o.fix_y         = fix_q[1];
  assign out_o.fix_z         = fix_q[2];
  assign out_o.parallel_flag = par_q;

  // both dividers carry the same word
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni) tl_v == tr_v)
    else $error("divider valid bits disagree");

  // parallel rays give a zero point
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.parallel_flag) |->
      (out_o.fix_x == '0 && out_o.fix_y == '0 && out_o.fix_z == '0))
    else $error("parallel word with nonzero point");

  // a nonparallel word always reaches the dividers with a nonzero divisor
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (f_v_q && !f_side_q.par) |-> (f_den_mag_q != '0))
    else $error("zero divisor on a nonparallel word");

  // an output word leaves only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $fell(out_valid_q) |-> $past(out_o.ready))
    else $error("output word dropped while stalled");

endmodule

FILE: src/trfp_div.sv
// trfp_div: pipelined restoring divider, 63-bit magnitude by 33-bit magnitude,
// 32 quotient bits plus overflow flag; depends on trfp_pkg

module trfp_div import trfp_pkg::*; #(
  parameter int unsigned StepsPerStage = DIV_STEPS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [62:0]       num_i,
  input  logic [32:0]       den_i,
  input  logic              neg_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o,
  output logic              neg_o
);

  localparam int unsigned Stages = QUO_W / StepsPerStage;

  logic              v_q   [Stages+1];
  logic [32:0]       rem_q [Stages+1];
  logic [QUO_W-1:0]  lo_q  [Stages+1];
  logic [QUO_W-1:0]  quo_q [Stages+1];
  logic [32:0]       den_q [Stages+1];
  logic              neg_q [Stages+1];
  logic              ovf_q [Stages+1];

  // entry stage: upper part of the numerator is the starting remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {2'b00, num_i[62:32]};
      lo_q[0]  <= num_i[31:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ({2'b00, num_i[62:32]} >= den_i);
    end
  end

  // iteration stages
  for (genvar k = 1; k <= Stages; k++) begin : g_stage
    logic [32:0]      rem_d;
    logic [QUO_W-1:0] lo_d;
    logic [QUO_W-1:0] quo_d;

    always_comb begin
      logic [33:0] r;
      rem_d = rem_q[k-1];
      lo_d  = lo_q[k-1];
      quo_d = quo_q[k-1];
      for (int s = 0; s < StepsPerStage; s++) begin
        r    = {rem_d, lo_d[QUO_W-1]};
        lo_d = {lo_d[QUO_W-2:0], 1'b0};
        if (r >= {1'b0, den_q[k-1]}) begin
          r     = r - {1'b0, den_q[k-1]};
          quo_d = {quo_d[QUO_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QUO_W-2:0], 1'b0};
        end
        rem_d = r[32:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        lo_q[k]  <= lo_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign valid_o = v_q[Stages];
  assign quo_o   = quo_q[Stages];
  assign ovf_o   = ovf_q[Stages];
  assign neg_o   = neg_q[Stages];

endmodule
